### src/kdb_pkg.sv
// Shared types and constants for the key debounce event block.
// Request and result payloads, state codes, event codes and key-pattern helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package kdb_pkg;

	// Key-pattern and event constants
	localparam logic [7:0] NO_KEYS     = 8'hFF;
	localparam logic [7:0] COMBO_KEYS  = 8'hF8;
	localparam logic [7:0] ROT2_KEYS   = 8'hFD;
	localparam logic [7:0] CNT_MAX     = 8'hFF;
	localparam logic [15:0] HELD_MAX   = 16'hFFFF;

	localparam logic [4:0] EV_NONE      = 5'd0;
	localparam logic [4:0] EV_DOWN_BASE = 5'd1;
	localparam logic [4:0] EV_UP_BASE   = 5'd9;
	localparam logic [4:0] EV_COMBO     = 5'd17;
	localparam logic [4:0] EV_LONG      = 5'd18;
	localparam logic [4:0] EV_UNDEF     = 5'd19;

	// Request commands
	localparam logic CMD_SCAN  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_JUDGE_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS  = 1'd1;

	typedef enum logic [2:0] {
		ST_INIT      = 3'd0,
		ST_IDLE      = 3'd1,
		ST_PRESS_JIT = 3'd2,
		ST_STABLE    = 3'd3,
		ST_REL_JIT   = 3'd4
	} state_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] key_lines;
	} req_t;

	typedef struct packed {
		logic [4:0] event_code;
		logic [7:0] filtered_keys;
	} rsp_t;

	// Event decision handed from the event decoder to the state machine
	typedef struct packed {
		logic       hit;
		logic [4:0] code;
	} event_t;

	typedef struct packed {
		logic       one;
		logic [2:0] idx;
	} single_t;

	// Find the one cleared bit of an active-low pattern, if exactly one is clear
	function automatic single_t single_key(input logic [7:0] pattern);
		single_t res;
		res.one = ($countones(~pattern) == 1);
		res.idx = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (!pattern[i]) begin
				res.idx = 3'(i);
			end
		end
		return res;
	endfunction

endpackage
`default_nettype wire

### src/kdb_event.sv
// Event decoder: picks the event code latched when a key pattern is accepted.
// Depends on kdb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kdb_event (
	input  wire logic [7:0]     now_keys,
	input  wire logic [7:0]     before_keys,
	output kdb_pkg::event_t     ev
);

	kdb_pkg::single_t now_one;
	kdb_pkg::single_t before_one;

	assign now_one    = kdb_pkg::single_key(now_keys);
	assign before_one = kdb_pkg::single_key(before_keys);

	// Release, combo, single down, or undefined pattern
	always_comb begin
		ev.hit  = 1'b1;
		ev.code = kdb_pkg::EV_UNDEF;
		if (now_keys == kdb_pkg::NO_KEYS) begin
			if (before_one.one) begin
				ev.code = kdb_pkg::EV_UP_BASE + {2'b00, before_one.idx};
			end
		end else if (now_keys == kdb_pkg::COMBO_KEYS) begin
			ev.code = kdb_pkg::EV_COMBO;
		end else if (now_one.one) begin
			// a key change between single keys keeps the pending event
			ev.hit  = (before_keys == kdb_pkg::NO_KEYS);
			ev.code = kdb_pkg::EV_DOWN_BASE + {2'b00, now_one.idx};
		end
	end

endmodule
`default_nettype wire

### src/key_debounce_event_fsm.sv
// A request is held in the input register at acceptance and its result is loaded into the
// result register when the request advances, which a stalled result can hold back.
// Throughput: one request per cycle; only a stalled result holds the input side.
// Reset: asynchronous, active low; state machine returns to init, patterns to 0xFF,
// counters and pending event to zero, judge_count to 3, long_press_ticks to 200.
// Depends on kdb_pkg and kdb_event.
`timescale 1ns / 1ps
`default_nettype none
module key_debounce_event_fsm #(
	parameter int KEY_LINES = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              sample_valid,
	output      logic                              sample_stall,
	input  wire kdb_pkg::req_t                     sample,
	output      logic                              result_valid,
	input  wire logic                              result_stall,
	output      kdb_pkg::rsp_t                     result,
	input  wire logic                              cfg_wr,
	input  wire logic [kdb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [15:0]                       cfg_data
);

	localparam logic [7:0] USED_MASK = 8'((9'd1 << KEY_LINES) - 9'd1);

	// Configuration registers
	logic [7:0]  judge_q;
	logic [15:0] long_ticks_q;

	// Input register
	logic          valid_s1;
	kdb_pkg::req_t req_s1;

	// Block state
	kdb_pkg::state_t state_q, state_d;
	logic [7:0]  cand_q, cand_d;
	logic [7:0]  acc_q, acc_d;
	logic [7:0]  cnt_q, cnt_d;
	logic        from_stable_q, from_stable_d;
	logic [4:0]  pend_q, pend_d;
	logic [15:0] held_q, held_d;

	logic [7:0]  cur;
	logic [7:0]  cnt_inc;
	logic [15:0] held_inc;
	logic        advance;
	logic        accept;
	kdb_pkg::event_t ev;

	// Handshake: the result register parts the two sides
	assign advance      = valid_s1 && (!result_valid || !result_stall);
	assign sample_stall = valid_s1 && !advance;
	assign accept       = sample_valid && !sample_stall;

	// Write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			judge_q      <= 8'd3;
			long_ticks_q <= 16'd200;
		end else if (cfg_wr) begin
			case (cfg_index)
				kdb_pkg::CFG_JUDGE_COUNT: judge_q      <= cfg_data[7:0];
				kdb_pkg::CFG_LONG_TICKS:  long_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= sample;
		end
	end

	assign cur      = req_s1.key_lines | ~USED_MASK;
	assign cnt_inc  = (cnt_q == kdb_pkg::CNT_MAX) ? cnt_q : cnt_q + 8'd1;
	assign held_inc = (held_q == kdb_pkg::HELD_MAX) ? held_q : held_q + 16'd1;

	kdb_event u_event (
		.now_keys    (cur),
		.before_keys (acc_q),
		.ev          (ev)
	);

	// Next state and state updates for one request
	always_comb begin
		state_d       = state_q;
		cand_d        = cand_q;
		acc_d         = acc_q;
		cnt_d         = cnt_q;
		from_stable_d = from_stable_q;
		pend_d        = pend_q;
		held_d        = held_q;
		if (req_s1.cmd == kdb_pkg::CMD_CLEAR) begin
			pend_d = kdb_pkg::EV_NONE;
		end else begin
			held_d = held_inc;
			case (state_q)
				kdb_pkg::ST_INIT: begin
					state_d = kdb_pkg::ST_IDLE;
				end
				kdb_pkg::ST_IDLE: begin
					if (cur != kdb_pkg::NO_KEYS) begin
						cnt_d         = 8'd1;
						cand_d        = cur;
						from_stable_d = 1'b0;
						state_d       = kdb_pkg::ST_PRESS_JIT;
					end
				end
				kdb_pkg::ST_PRESS_JIT: begin
					if (cur == cand_q) begin
						cnt_d = cnt_inc;
						if (cnt_inc >= judge_q) begin
							if (ev.hit) begin
								pend_d = ev.code;
							end
							acc_d   = cur;
							state_d = kdb_pkg::ST_STABLE;
							held_d  = 16'd0;
						end
					end else begin
						state_d = from_stable_q ? kdb_pkg::ST_STABLE : kdb_pkg::ST_IDLE;
					end
				end
				kdb_pkg::ST_STABLE: begin
					if (cur != acc_q) begin
						cand_d = cur;
						cnt_d  = 8'd1;
						if (cur == kdb_pkg::NO_KEYS) begin
							state_d = kdb_pkg::ST_REL_JIT;
						end else begin
							from_stable_d = 1'b1;
							state_d       = kdb_pkg::ST_PRESS_JIT;
						end
					end else if (acc_q == kdb_pkg::ROT2_KEYS && held_inc >= long_ticks_q) begin
						pend_d = kdb_pkg::EV_LONG;
					end
				end
				kdb_pkg::ST_REL_JIT: begin
					if (cur == kdb_pkg::NO_KEYS) begin
						cnt_d = cnt_inc;
						if (cnt_inc >= judge_q) begin
							if (ev.hit) begin
								pend_d = ev.code;
							end
							acc_d   = cur;
							state_d = kdb_pkg::ST_IDLE;
						end
					end else begin
						state_d = kdb_pkg::ST_STABLE;
					end
				end
				default: begin
					state_d = kdb_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Hold the state machine and its registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= kdb_pkg::ST_INIT;
			cand_q        <= kdb_pkg::NO_KEYS;
			acc_q         <= kdb_pkg::NO_KEYS;
			cnt_q         <= 8'd0;
			from_stable_q <= 1'b0;
			pend_q        <= kdb_pkg::EV_NONE;
			held_q        <= 16'd0;
		end else if (advance) begin
			state_q       <= state_d;
			cand_q        <= cand_d;
			acc_q         <= acc_d;
			cnt_q         <= cnt_d;
			from_stable_q <= from_stable_d;
			pend_q        <= pend_d;
			held_q        <= held_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result.event_code    <= pend_d;
			result.filtered_keys <= acc_d;
		end
	end

endmodule
`default_nettype wire

### tb/key_debounce_event_fsm_tb.sv
// Self-checking bench for key_debounce_event_fsm: directed key strokes, then random
// press/hold/release sequences mostly under random idling, checked against a debounce
// predictor. Depends on kdb_pkg and the key_debounce_event_fsm RTL.
`timescale 1ns / 1ps
`default_nettype none
module key_debounce_event_fsm_tb;

	localparam int KEY_LINES = 8;
	localparam logic [7:0] KEY_MASK = 8'((1 << KEY_LINES) - 1);
	localparam int CYCLE_LIMIT = 800000;
	localparam int HOLD_OFF_AT = 300;
	localparam int HOLD_OFF_LEN = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	kdb_pkg::req_t sample = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	kdb_pkg::rsp_t result;
	logic cfg_wr = 1'b0;
	logic [kdb_pkg::CFG_IDX_W-1:0] cfg_index = kdb_pkg::CFG_JUDGE_COUNT;
	logic [15:0] cfg_data = '0;

	// Predictor copy of the scanner state and its registers
	kdb_pkg::state_t scan_state = kdb_pkg::ST_INIT;
	logic [7:0] cand_keys = kdb_pkg::NO_KEYS;
	logic [7:0] accepted_keys = kdb_pkg::NO_KEYS;
	logic [7:0] equal_scans = '0;
	logic jitter_from_stable = 1'b0;
	logic [4:0] pending_ev = kdb_pkg::EV_NONE;
	logic [15:0] held_ticks = '0;
	logic [7:0] judge_count = 8'd3;
	logic [15:0] long_ticks = 16'd200;

	kdb_pkg::req_t keypad_requests[$];
	kdb_pkg::rsp_t expected_events[$];
	int items_queued = 0;
	int requests_taken = 0;
	int events_matched = 0;
	int errors = 0;
	int cycle_count = 0;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit hold_off_done = 1'b0;
	bit calm = 1'b0;

	key_debounce_event_fsm #(
		.KEY_LINES(KEY_LINES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_wr(cfg_wr),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Bit index of the only pressed line, or -1 when not exactly one is pressed
	function automatic int lone_key(logic [7:0] pattern);
		int k;
		k = -1;
		if ($countones(~pattern) == 1) begin
			for (int i = 0; i < 8; i++) begin
				if (!pattern[i]) begin
					k = i;
				end
			end
		end
		return k;
	endfunction

	// Decide which event an accepted pattern change raises
	function automatic void latch_key_event(logic [7:0] now_keys, logic [7:0] prev_keys);
		int k;
		if (now_keys == kdb_pkg::NO_KEYS) begin
			k = lone_key(prev_keys);
			pending_ev = (k >= 0) ? kdb_pkg::EV_UP_BASE + 5'(k) : kdb_pkg::EV_UNDEF;
		end else if (now_keys == kdb_pkg::COMBO_KEYS) begin
			pending_ev = kdb_pkg::EV_COMBO;
		end else begin
			k = lone_key(now_keys);
			if (k < 0) begin
				pending_ev = kdb_pkg::EV_UNDEF;
			end else if (prev_keys == kdb_pkg::NO_KEYS) begin
				pending_ev = kdb_pkg::EV_DOWN_BASE + 5'(k);
			end
		end
	endfunction

	// Advance the predicted scanner by one request and return its result
	function automatic kdb_pkg::rsp_t debounce_step(kdb_pkg::req_t r);
		logic [7:0] cur;
		kdb_pkg::rsp_t o;
		if (r.cmd == kdb_pkg::CMD_CLEAR) begin
			pending_ev = kdb_pkg::EV_NONE;
		end else begin
			cur = r.key_lines | ~KEY_MASK;
			if (held_ticks != kdb_pkg::HELD_MAX) begin
				held_ticks++;
			end
			case (scan_state)
				kdb_pkg::ST_INIT: begin
					scan_state = kdb_pkg::ST_IDLE;
				end
				kdb_pkg::ST_IDLE: begin
					if (cur != kdb_pkg::NO_KEYS) begin
						equal_scans = 8'd1;
						cand_keys = cur;
						jitter_from_stable = 1'b0;
						scan_state = kdb_pkg::ST_PRESS_JIT;
					end
				end
				kdb_pkg::ST_PRESS_JIT: begin
					if (cur == cand_keys) begin
						if (equal_scans != kdb_pkg::CNT_MAX) begin
							equal_scans++;
						end
						if (equal_scans >= judge_count) begin
							latch_key_event(cur, accepted_keys);
							accepted_keys = cur;
							scan_state = kdb_pkg::ST_STABLE;
							held_ticks = '0;
						end
					end else begin
						scan_state = jitter_from_stable ? kdb_pkg::ST_STABLE : kdb_pkg::ST_IDLE;
					end
				end
				kdb_pkg::ST_STABLE: begin
					if (cur != accepted_keys) begin
						cand_keys = cur;
						equal_scans = 8'd1;
						if (cur == kdb_pkg::NO_KEYS) begin
							scan_state = kdb_pkg::ST_REL_JIT;
						end else begin
							jitter_from_stable = 1'b1;
							scan_state = kdb_pkg::ST_PRESS_JIT;
						end
					end else if (accepted_keys == kdb_pkg::ROT2_KEYS
						&& held_ticks >= long_ticks) begin
						pending_ev = kdb_pkg::EV_LONG;
					end
				end
				kdb_pkg::ST_REL_JIT: begin
					if (cur == kdb_pkg::NO_KEYS) begin
						if (equal_scans != kdb_pkg::CNT_MAX) begin
							equal_scans++;
						end
						if (equal_scans >= judge_count) begin
							latch_key_event(cur, accepted_keys);
							accepted_keys = cur;
							scan_state = kdb_pkg::ST_IDLE;
						end
					end else begin
						scan_state = kdb_pkg::ST_STABLE;
					end
				end
				default: begin
					scan_state = kdb_pkg::ST_IDLE;
				end
			endcase
		end
		o.event_code = pending_ev;
		o.filtered_keys = accepted_keys;
		return o;
	endfunction

	// Offer queued requests, predicting each one as it is taken
	always @(posedge clk) begin : drive
		logic nxt_valid;
		kdb_pkg::req_t nxt_req;
		if (arst_n) begin
			nxt_valid = sample_valid;
			nxt_req = sample;
			if (sample_valid && !sample_stall) begin
				expected_events.push_back(debounce_step(sample));
				requests_taken <= requests_taken + 1;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (keypad_requests.size() > 0) begin
					nxt_req = keypad_requests.pop_front();
					nxt_valid = 1'b1;
					if (!calm && $urandom_range(0, 9) == 0) begin
						send_gap = $urandom_range(1, 15);
					end
				end
			end
			sample_valid <= nxt_valid;
			sample <= nxt_req;
		end
	end

	// Stall the result side in bursts, with one long hold-off to back the block up
	always @(posedge clk) begin : backpressure
		logic nxt_stall;
		if (arst_n) begin
			if (!hold_off_done && requests_taken >= HOLD_OFF_AT) begin
				hold_left = HOLD_OFF_LEN;
				hold_off_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				nxt_stall = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				nxt_stall = 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 15) - 1;
				nxt_stall = 1'b1;
			end else begin
				nxt_stall = 1'b0;
			end
			result_stall <= nxt_stall;
		end
	end

	// Compare each taken result with the oldest predicted event
	always @(posedge clk) begin : check
		kdb_pkg::rsp_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_events.size() == 0) begin
				errors <= errors + 1;
				$display("%0t: result with nothing pending: event %0d keys %02h", $time,
					result.event_code, result.filtered_keys);
			end else begin
				want = expected_events.pop_front();
				events_matched <= events_matched + 1;
				if (result.event_code !== want.event_code
					|| result.filtered_keys !== want.filtered_keys) begin
					errors <= errors + 1;
					if (result.event_code !== want.event_code) begin
						$display("%0t: event_code expected %0d got %0d", $time,
							want.event_code, result.event_code);
					end
					if (result.filtered_keys !== want.filtered_keys) begin
						$display("%0t: filtered_keys expected %02h got %02h", $time,
							want.filtered_keys, result.filtered_keys);
					end
				end
			end
		end
	end

	// Give up if the run hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic push_req(logic c, logic [7:0] k);
		kdb_pkg::req_t r;
		r.cmd = c;
		r.key_lines = k;
		keypad_requests.push_back(r);
		items_queued++;
	endtask

	task automatic push_scans(logic [7:0] k, int n);
		repeat (n) push_req(kdb_pkg::CMD_SCAN, k);
	endtask

	task automatic write_reg(logic [kdb_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_wr <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr <= 1'b0;
		if (idx == kdb_pkg::CFG_JUDGE_COUNT) begin
			judge_count = val[7:0];
		end else begin
			long_ticks = val;
		end
	endtask

	// Hold until every queued request has come back checked
	task automatic drain;
		while (events_matched != items_queued) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// Mostly well-formed key strokes with random content, plus some noise
	task automatic queue_random_phase(int count);
		int stop_at;
		int hold;
		logic [7:0] key;
		stop_at = items_queued + count;
		while (items_queued < stop_at) begin
			if ($urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(1, 4)) push_req(1'($urandom), 8'($urandom));
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: key = ~(8'h01 << $urandom_range(0, 7));
					5, 6: key = kdb_pkg::ROT2_KEYS;
					7: key = kdb_pkg::COMBO_KEYS;
					8: key = 8'($urandom);
					default: key = 8'h00;
				endcase
				// bounce before the press settles
				if ($urandom_range(0, 2) == 0) begin
					repeat ($urandom_range(1, 3)) push_req(kdb_pkg::CMD_SCAN, 8'($urandom));
				end
				hold = int'(judge_count) + $urandom_range(0, 3);
				if (key == kdb_pkg::ROT2_KEYS && long_ticks < 100
					&& $urandom_range(0, 1) == 1) begin
					hold = int'(judge_count) + int'(long_ticks) + $urandom_range(0, 4);
				end
				for (int i = 0; i < hold; i++) begin
					push_req(kdb_pkg::CMD_SCAN, key);
					if ($urandom_range(0, 19) == 0) begin
						push_req(kdb_pkg::CMD_CLEAR, 8'($urandom));
					end
				end
				// roll over to another pattern while still held
				if ($urandom_range(0, 3) == 0) begin
					key = $urandom_range(0, 1) ? kdb_pkg::COMBO_KEYS
						: ~(8'h01 << $urandom_range(0, 7));
					push_scans(key, int'(judge_count) + 1);
				end
				if ($urandom_range(0, 2) == 0) begin
					push_req(kdb_pkg::CMD_SCAN, kdb_pkg::NO_KEYS);
					push_req(kdb_pkg::CMD_SCAN, key);
				end
				push_scans(kdb_pkg::NO_KEYS, int'(judge_count) + $urandom_range(0, 3));
				if ($urandom_range(0, 2) == 0) begin
					push_req(kdb_pkg::CMD_CLEAR, 8'($urandom));
				end
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: first scan is ignored, then a press and release of the bit-2 key
		push_scans(8'h00, 1);
		push_scans(8'hFB, 3);
		push_scans(kdb_pkg::NO_KEYS, 3);
		drain();

		write_reg(kdb_pkg::CFG_JUDGE_COUNT, 16'd1);
		write_reg(kdb_pkg::CFG_LONG_TICKS, 16'd2);
		push_scans(8'hFE, 2);
		push_scans(kdb_pkg::NO_KEYS, 2);
		// rotary2 held into a long press, cleared, then raised again
		push_scans(kdb_pkg::ROT2_KEYS, 4);
		push_req(kdb_pkg::CMD_CLEAR, 8'h00);
		push_scans(kdb_pkg::ROT2_KEYS, 1);
		push_scans(kdb_pkg::COMBO_KEYS, 2);
		// press bounce back to the held combo, release bounce back too
		push_scans(8'h7F, 1);
		push_scans(kdb_pkg::COMBO_KEYS, 1);
		push_scans(kdb_pkg::NO_KEYS, 1);
		push_scans(8'h00, 1);
		push_scans(kdb_pkg::NO_KEYS, 2);
		push_req(kdb_pkg::CMD_CLEAR, 8'hFF);
		push_scans(8'h00, 2);
		// single key accepted over a held pattern raises nothing new
		push_scans(8'h7F, 2);
		push_scans(kdb_pkg::NO_KEYS, 2);
		drain();

		write_reg(kdb_pkg::CFG_JUDGE_COUNT, 16'd2);
		write_reg(kdb_pkg::CFG_LONG_TICKS, 16'd1);
		queue_random_phase(260);
		drain();

		write_reg(kdb_pkg::CFG_JUDGE_COUNT, 16'd1);
		write_reg(kdb_pkg::CFG_LONG_TICKS, 16'($urandom_range(3, 20)));
		queue_random_phase(260);
		drain();

		write_reg(kdb_pkg::CFG_JUDGE_COUNT, 16'($urandom_range(3, 6)));
		write_reg(kdb_pkg::CFG_LONG_TICKS, 16'($urandom_range(5, 40)));
		queue_random_phase(260);
		drain();

		write_reg(kdb_pkg::CFG_JUDGE_COUNT, {8'($urandom), 8'd4});
		write_reg(kdb_pkg::CFG_LONG_TICKS, 16'hFFFF);
		queue_random_phase(260);
		drain();

		// Last part runs without idling on either side
		calm = 1'b1;
		write_reg(kdb_pkg::CFG_JUDGE_COUNT, 16'($urandom_range(1, 3)));
		write_reg(kdb_pkg::CFG_LONG_TICKS, 16'($urandom_range(2, 12)));
		queue_random_phase(260);
		drain();

		// Slowest judge, then a rotary2 long press, a clear and a slow release
		write_reg(kdb_pkg::CFG_JUDGE_COUNT, {8'($urandom), 8'd255});
		write_reg(kdb_pkg::CFG_LONG_TICKS, 16'd40);
		push_scans(kdb_pkg::NO_KEYS, 4);
		push_scans(kdb_pkg::ROT2_KEYS, 255 + 44);
		push_req(kdb_pkg::CMD_CLEAR, 8'h00);
		push_scans(kdb_pkg::ROT2_KEYS, 2);
		push_scans(kdb_pkg::NO_KEYS, 260);
		drain();

		repeat (8) @(posedge clk);
		if (errors == 0 && expected_events.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
`default_nettype wire

### key_debounce_event_fsm.f
src/kdb_pkg.sv
src/kdb_event.sv
src/key_debounce_event_fsm.sv
tb/key_debounce_event_fsm_tb.sv
